// ===== design/ptdb_pkg.sv =====
// ----------------------------------------------------------------------------
// ptdb_pkg
// Shared types, field widths, codes and the log2 table builder for the
// power-to-dB block.
// ----------------------------------------------------------------------------
package ptdb_pkg;

   localparam int POWER_W  = 32;   // unsigned Q16.16 power
   localparam int INDEX_W  = 12;   // entry index field
   localparam int DB_W     = 16;   // signed Q8.8 dB
   localparam int TOP_DB_W = 15;   // floor depth register
   localparam int FRAC_W   = 16;   // Q0.16 log2 fraction
   localparam int EXP_W    = 5;    // leading-one position 0..31
   localparam int LOG_W    = EXP_W + FRAC_W;
   localparam int SCALE_W  = 18;
   localparam int PROD_W   = LOG_W + SCALE_W;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 16;

   localparam logic [TOP_DB_W-1:0] TOP_DB_RESET    = 15'd20480;
   // round(2^16 * 10 * log10(2))
   localparam logic [SCALE_W-1:0]  DB_PER_LOG2_Q16 = 18'd197283;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_UNLOADED = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOG,
      ST_MUL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic first;
      logic read;
   } store_ctl_type;

   // log2(1 + idx/2^bits) in Q0.16 by repeated squaring, MSB first.
   // Evaluated only on constants while the table is built.
   function automatic logic [FRAC_W-1:0] frac_log2(input int idx, input int bits);
      logic [63:0]       x;
      logic [FRAC_W-1:0] r;
      int                k;
      x = (64'(1) << bits) + 64'(idx);
      x = x << (30 - bits);
      r = '0;
      for (k = 0; k < FRAC_W; k++) begin
         x = (x * x) >> 30;
         if (x >= (64'(1) << 31)) begin
            x = x >> 1;
            r[FRAC_W-1-k] = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

// ===== design/power_to_db_ref_max_core.sv =====
// ----------------------------------------------------------------------------
// power_to_db_ref_max_core
// Mel power store with peak tracking and dB readout relative to the peak.
// ----------------------------------------------------------------------------
// A load beat (tuser = 0) writes one Q16.16 power value at the next free
// entry and updates the set peak in the same cycle, so loads stream at one
// beat per clock while no read is in flight; first_flag restarts the set,
// and loads into a full store are dropped. A read beat (tuser = 1) returns
// 10*log10(max(p,eps)/peak) in signed Q8.8 dB, clamped at -top_db, or
// status 1 with level 0 for an entry not yet loaded. A read blocks the
// input while it runs: one memory read, five normalizer steps and a table
// lookup in the log2 units, then a subtract, a multiply and the clamp; an
// unloaded read blocks the input only while its status is emitted. Either
// waits longer while the output register still holds an earlier result.
// The result sits in an output register, so the next beat is taken while it
// waits. Write top_db only while the block is idle.
// ----------------------------------------------------------------------------
module power_to_db_ref_max_core import ptdb_pkg::*; #(
   parameter int CAPACITY       = 4096,
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] power_value, [32] first_flag, [44:33] entry_index, [47:45] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] opcode
   input  logic                   req_tuser,
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] db_value
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [0] status
   output logic                   rsp_tuser,
   // configuration
   input  logic                   csr_wr_en,
   input  logic [TOP_DB_W-1:0]    csr_wr_data
);

   // ---- request fields ----
   logic [POWER_W-1:0] req_power_value;
   logic               req_first_flag;
   logic [INDEX_W-1:0] req_entry_index;
   logic               req_beat;

   assign req_power_value = req_tdata[31:0];
   assign req_first_flag  = req_tdata[32];
   assign req_entry_index = req_tdata[44:33];
   assign req_beat        = req_tvalid && req_tready;

   // ---- registers ----
   state_type             state_ff, state_in;
   logic                  err_ff, err_in;
   logic [LOG_W-1:0]      d_ff, d_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DB_W-1:0]       rsp_db_ff, rsp_db_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [TOP_DB_W-1:0]   top_db_ff, top_db_in;

   // ---- submodule wiring ----
   store_ctl_type         store_ctl;
   logic                  rd_hit;
   logic [POWER_W-1:0]    rd_data;
   logic [POWER_W-1:0]    peak;
   logic                  log_start;
   logic                  lp_done, lk_done;
   logic [LOG_W-1:0]      lp_value, lk_value;

   // ---- scaling ----
   logic [PROD_W-1:0]     rounded;
   logic [TOP_DB_W-1:0]   mag;
   logic [TOP_DB_W-1:0]   clip;
   logic                  out_free;

   ptdb_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (store_ctl),
      .wr_value (req_power_value),
      .rd_index (req_entry_index),
      .rd_hit   (rd_hit),
      .rd_data  (rd_data),
      .peak     (peak)
   );

   // log2 of the stored power
   ptdb_log #(
      .LOG_TABLE_BITS (LOG_TABLE_BITS)
   ) u_log_power (
      .clock     (clock),
      .reset     (reset),
      .start     (log_start),
      .operand   (rd_data),
      .done      (lp_done),
      .log_value (lp_value)
   );

   // log2 of the set peak; the peak cannot move while a read is in flight
   ptdb_log #(
      .LOG_TABLE_BITS (LOG_TABLE_BITS)
   ) u_log_peak (
      .clock     (clock),
      .reset     (reset),
      .start     (log_start),
      .operand   (peak),
      .done      (lk_done),
      .log_value (lk_value)
   );

   always_comb begin
      // round the Q32 product to whole 1/256 dB; always fits 15 bits
      rounded  = prod_ff + (PROD_W'(1) << 23);
      mag      = rounded[PROD_W-1 -: TOP_DB_W];
      clip     = (mag > top_db_ff) ? top_db_ff : mag;
      out_free = !rsp_valid_ff || rsp_tready;
   end

   // ---- sequencer ----
   always_comb begin
      state_in      = state_ff;
      err_in        = err_ff;
      d_in          = d_ff;
      prod_in       = prod_ff;
      rsp_db_in     = rsp_db_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      top_db_in     = csr_wr_en ? csr_wr_data : top_db_ff;
      store_ctl     = '0;
      log_start     = 1'b0;
      req_tready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == OP_LOAD) begin
                  // store and peak update complete in this cycle
                  store_ctl.load  = 1'b1;
                  store_ctl.first = req_first_flag;
               end else begin
                  store_ctl.read = 1'b1;
                  err_in         = !rd_hit;
                  state_in       = rd_hit ? ST_FETCH : ST_EMIT;
               end
            end
         end
         ST_FETCH: begin
            // memory data is out; launch both log units together
            log_start = 1'b1;
            state_in  = ST_LOG;
         end
         ST_LOG: begin
            if (lp_done) begin
               d_in     = (lk_value > lp_value) ? (lk_value - lp_value) : '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(d_ff) * PROD_W'(DB_PER_LOG2_Q16);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_db_in     = '0;
                  rsp_status_in = STATUS_UNLOADED;
               end else begin
                  rsp_db_in     = DB_W'(0) - {1'b0, clip};
                  rsp_status_in = STATUS_OK;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         top_db_ff    <= TOP_DB_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         top_db_ff    <= top_db_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff        <= err_in;
      d_ff          <= d_in;
      prod_ff       <= prod_in;
      rsp_db_ff     <= rsp_db_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_db_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   // both log units run in lockstep
   a_log_lockstep: assert property (@(posedge clock) disable iff (reset)
      lp_done == lk_done)
      else $error("log units out of step");

   // a read beat blocks the input on the next cycle
   a_read_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_tuser == OP_READ) |=> !req_tready)
      else $error("input taken during a read");

   // an unloaded entry reads as level zero
   a_unloaded_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_UNLOADED) |-> rsp_tdata == '0)
      else $error("unloaded read with nonzero level");

   // the level stays between the floor and zero
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_OK) |->
         ($signed(rsp_tdata) <= 0 &&
          $signed({rsp_tdata[DB_W-1], rsp_tdata}) >=
             $signed(17'(0) - {2'b0, top_db_ff})))
      else $error("level outside floor range");
`endif

endmodule

// ===== design/ptdb_store.sv =====
// ----------------------------------------------------------------------------
// ptdb_store
// Power store memory with fill count and running peak of the current set.
// ----------------------------------------------------------------------------
module ptdb_store import ptdb_pkg::*; #(
   parameter int CAPACITY = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  store_ctl_type       ctl,
   input  logic [POWER_W-1:0]  wr_value,
   input  logic [INDEX_W-1:0]  rd_index,
   output logic                rd_hit,
   output logic [POWER_W-1:0]  rd_data,
   output logic [POWER_W-1:0]  peak
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic [POWER_W-1:0] mem [CAPACITY];
   logic [POWER_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [POWER_W-1:0] peak_ff, peak_in;

   logic [CNT_W-1:0]   base;
   logic [POWER_W-1:0] peak_base;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;

   always_comb begin
      base      = ctl.first ? '0 : count_ff;
      peak_base = ctl.first ? POWER_W'(1) : peak_ff;
      // drop a load into a full store unless it opens a new set
      wr_en     = ctl.load && (ctl.first || (count_ff < CNT_W'(CAPACITY)));
      wr_addr   = ADDR_W'(base);
      rd_addr   = ADDR_W'(rd_index);
      count_in  = wr_en ? (base + CNT_W'(1)) : count_ff;
      if (wr_en) begin
         peak_in = (wr_value > peak_base) ? wr_value : peak_base;
      end else begin
         peak_in = peak_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_value;
      end
      if (ctl.read) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         peak_ff  <= POWER_W'(1);
      end else begin
         count_ff <= count_in;
         peak_ff  <= peak_in;
      end
   end

   assign rd_hit  = 32'(rd_index) < 32'(count_ff);
   assign rd_data = rd_data_ff;
   assign peak    = peak_ff;

endmodule

// ===== design/ptdb_log.sv =====
// ----------------------------------------------------------------------------
// ptdb_log
// Multi-cycle log2 in Q5.16: five-step binary normalizer, then table lookup.
// ----------------------------------------------------------------------------
module ptdb_log import ptdb_pkg::*; #(
   parameter int LOG_TABLE_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [POWER_W-1:0] operand,
   output logic               done,
   output logic [LOG_W-1:0]   log_value
);

   localparam int          TBL_SIZE = 1 << LOG_TABLE_BITS;
   localparam logic [2:0]  STEP_TBL = 3'd5;

   logic [FRAC_W-1:0] tbl [TBL_SIZE];

   for (genvar g = 0; g < TBL_SIZE; g++) begin : g_tbl
      assign tbl[g] = frac_log2(g, LOG_TABLE_BITS);
   end

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [2:0]         step_ff, step_in;
   logic [POWER_W-1:0] norm_ff, norm_in;
   logic [EXP_W-1:0]   lz_ff, lz_in;
   logic [LOG_W-1:0]   log_ff, log_in;

   logic                      shift_en;
   logic [EXP_W-1:0]          amt;
   logic [EXP_W-1:0]          exp_val;
   logic [LOG_TABLE_BITS-1:0] frac;

   always_comb begin
      case (step_ff)
         3'd0: begin amt = 5'd16; shift_en = (norm_ff[31:16] == '0); end
         3'd1: begin amt = 5'd8;  shift_en = (norm_ff[31:24] == '0); end
         3'd2: begin amt = 5'd4;  shift_en = (norm_ff[31:28] == '0); end
         3'd3: begin amt = 5'd2;  shift_en = (norm_ff[31:30] == '0); end
         3'd4: begin amt = 5'd1;  shift_en = !norm_ff[31];           end
         default: begin amt = '0; shift_en = 1'b0; end
      endcase

      exp_val = 5'd31 - lz_ff;
      frac    = norm_ff[30 -: LOG_TABLE_BITS];

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      norm_in = norm_ff;
      lz_in   = lz_ff;
      log_in  = log_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         norm_in = (operand == '0) ? POWER_W'(1) : operand;
         lz_in   = '0;
      end else if (busy_ff) begin
         if (step_ff == STEP_TBL) begin
            log_in  = {exp_val, {FRAC_W{1'b0}}} + LOG_W'(tbl[frac]);
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 3'd1;
            if (shift_en) begin
               norm_in = norm_ff << amt;
               lz_in   = lz_ff + amt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      norm_ff <= norm_in;
      lz_ff   <= lz_in;
      log_ff  <= log_in;
   end

   assign done      = done_ff;
   assign log_value = log_ff;

endmodule

// ===== tb/power_to_db_ref_max_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// power_to_db_ref_max_core_test
// Self-checking bench for the power store and dB readout relative to the peak.
// ----------------------------------------------------------------------------
// A short table of directed beats runs first: reset state, zero power, the
// largest and smallest powers, restarts of the set and reads past the loaded
// count. Random sets of loads and reads follow under several floor depths,
// from zero to the largest. Every read beat is checked field by field against
// a fixed level from its directed row or an in-bench predictor of the store,
// the peak and the log2 arithmetic. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module power_to_db_ref_max_core_test import ptdb_pkg::*;;

   localparam int STORE_DEPTH = 4096;
   localparam int TBL_BITS    = 8;
   // settle time after the last response
   localparam int DRAIN_CYCLES = 40;

   typedef enum logic {CHK_MODEL, CHK_FIXED} chk_kind_type;

   typedef struct {
      logic                op;
      logic [POWER_W-1:0]  pwr;
      logic                first;
      logic [INDEX_W-1:0]  idx;
   } beat_type;

   typedef struct {
      logic [DB_W-1:0] db;
      logic            st;
   } level_type;

   typedef struct {
      logic                op;
      logic [POWER_W-1:0]  pwr;
      logic                first;
      logic [INDEX_W-1:0]  idx;
      chk_kind_type        chk;
      logic [DB_W-1:0]     db;
      logic                st;
   } dir_row_type;

   // DUT ports
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = OP_LOAD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wr_en = 1'b0;
   logic [TOP_DB_W-1:0]    csr_wr_data = '0;

   // predictor state
   logic [POWER_W-1:0]  shadow_power [STORE_DEPTH];
   logic [12:0]         shadow_count;
   logic [POWER_W-1:0]  shadow_peak;
   logic [TOP_DB_W-1:0] floor_depth;
   logic [FRAC_W-1:0]   frac_tbl [1 << TBL_BITS];

   level_type pending_levels [$];
   int        fault_count = 0;
   bit        gaps_on = 1'b1;

   dir_row_type dir_tbl [21];

   power_to_db_ref_max_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // log2(1 + i/2^B) in Q0.16: square a Q1.30 value 16 times, one bit per step
   function automatic logic [FRAC_W-1:0] frac_bits(input int i);
      logic [63:0]       acc;
      logic [FRAC_W-1:0] r;
      acc = 64'((1 << TBL_BITS) + i) << (30 - TBL_BITS);
      r   = '0;
      for (int k = 0; k < FRAC_W; k++) begin
         acc = (acc * acc) >> 30;
         if (acc[63:31] != 0) begin
            acc = acc >> 1;
            r[FRAC_W-1-k] = 1'b1;
         end
      end
      return r;
   endfunction

   // Q5.16 log2: leading-one position above the table fraction
   function automatic logic [LOG_W-1:0] log2_fix(input logic [POWER_W-1:0] x);
      int                  e;
      logic [TBL_BITS-1:0] f;
      if (x == '0) x = 1;
      e = 0;
      for (int b = 0; b < POWER_W; b++)
         if (x[b]) e = b;
      if (e >= TBL_BITS) f = TBL_BITS'(x >> (e - TBL_BITS));
      else f = TBL_BITS'(x << (TBL_BITS - e));
      return {EXP_W'(e), frac_tbl[f]};
   endfunction

   function automatic logic [DB_W-1:0] level_of(input logic [POWER_W-1:0] p);
      logic [LOG_W-1:0] lp, lk, d;
      logic [63:0]      mag;
      int               lvl;
      lp  = log2_fix(p);
      lk  = log2_fix(shadow_peak);
      d   = (lk > lp) ? lk - lp : '0;
      mag = (64'(d) * 64'(DB_PER_LOG2_Q16) + 64'h80_0000) >> 24;
      if (mag > 64'd32768) mag = 64'd32768;
      lvl = -int'(mag);
      if (lvl < -int'(floor_depth)) lvl = -int'(floor_depth);
      if (lvl > 0) lvl = 0;
      return DB_W'(lvl);
   endfunction

   // advance the shadow state by one accepted beat; reads yield a level
   function automatic bit track_beat(input beat_type b, output level_type r);
      r.db = '0;
      r.st = STATUS_OK;
      if (b.op == OP_LOAD) begin
         if (b.first) begin
            shadow_count = '0;
            shadow_peak  = 1;
         end
         if (shadow_count < STORE_DEPTH) begin
            shadow_power[shadow_count[INDEX_W-1:0]] = b.pwr;
            shadow_count = shadow_count + 13'd1;
            if (b.pwr > shadow_peak) shadow_peak = b.pwr;
         end
         return 1'b0;
      end
      if (13'(b.idx) >= shadow_count) begin
         r.st = STATUS_UNLOADED;
      end else begin
         r.db = level_of(shadow_power[b.idx]);
      end
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // spread the leading one over all 32 positions, with the corners
   function automatic logic [POWER_W-1:0] rand_power();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r == 2) return 1;
      return $urandom >> $urandom_range(0, 31);
   endfunction

   // fields a beat does not use carry random noise
   function automatic beat_type make_load(input logic first);
      beat_type b;
      b.op    = OP_LOAD;
      b.pwr   = rand_power();
      b.first = first;
      b.idx   = INDEX_W'($urandom);
      return b;
   endfunction

   function automatic beat_type make_read(input logic [INDEX_W-1:0] idx);
      beat_type b;
      b.op    = OP_READ;
      b.pwr   = $urandom;
      b.first = 1'($urandom);
      b.idx   = idx;
      return b;
   endfunction

   // mostly loaded entries, some just past the count, some anywhere
   function automatic logic [INDEX_W-1:0] pick_index();
      int r;
      r = $urandom_range(0, 9);
      if (shadow_count == 0 || r == 0) return INDEX_W'($urandom);
      if (r == 1) return INDEX_W'(shadow_count);
      return INDEX_W'($urandom_range(0, shadow_count - 1));
   endfunction

   // drive one beat and hold it until taken; keep tvalid high across
   // back-to-back beats
   task automatic send_beat(input beat_type b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {3'b000, b.idx, b.first, b.pwr};
      req_tuser  <= b.op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic issue(input beat_type b, input chk_kind_type chk,
                        input logic [DB_W-1:0] db, input logic st);
      level_type r;
      bit        has_rsp;
      send_beat(b);
      has_rsp = track_beat(b, r);
      if (has_rsp) begin
         if (chk == CHK_FIXED) begin
            r.db = db;
            r.st = st;
         end
         pending_levels.push_back(r);
      end
   endtask

   task automatic issue_model(input beat_type b);
      issue(b, CHK_MODEL, '0, STATUS_OK);
   endtask

   // write the floor depth only with the block idle
   task automatic write_top_db(input logic [TOP_DB_W-1:0] v);
      req_tvalid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      floor_depth = v;
   endtask

   // well-formed sets of random size with reads mixed in; now and then a
   // restart lands mid-set or a set carries on without one
   task automatic run_sets(input int n);
      int done, k, loads_left, reads_left;
      done = 0;
      while (done < n) begin
         k = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
         issue_model(make_load($urandom_range(0, 19) != 0));
         done++;
         loads_left = k - 1;
         reads_left = k / 2 + $urandom_range(1, 4);
         while (loads_left > 0 || reads_left > 0) begin
            if (loads_left > 0 && (reads_left == 0 || $urandom_range(0, 2) != 0)) begin
               issue_model(make_load($urandom_range(0, 49) == 0));
               loads_left--;
            end else begin
               issue_model(make_read(pick_index()));
               reads_left--;
            end
            done++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      logic [DB_W-1:0] floor_level;
      for (int i = 0; i < (1 << TBL_BITS); i++)
         frac_tbl[i] = frac_bits(i);
      for (int i = 0; i < STORE_DEPTH; i++)
         shadow_power[i] = '0;
      shadow_count = '0;
      shadow_peak  = 1;
      floor_depth  = TOP_DB_RESET;
      floor_level  = DB_W'(-int'(TOP_DB_RESET));

      // directed rows: op, power, first, index, check, level, status
      dir_tbl = '{
         // reads right after reset find nothing loaded
         '{OP_READ, 32'h0000_0000, 1'b0, 12'h000, CHK_FIXED, 16'h0000, STATUS_UNLOADED},
         '{OP_READ, 32'hFFFF_FFFF, 1'b1, 12'hFFF, CHK_FIXED, 16'h0000, STATUS_UNLOADED},
         // one set: 1.0, zero power, the largest power, one LSB
         '{OP_LOAD, 32'h0001_0000, 1'b1, 12'hFFF, CHK_MODEL, 16'h0000, STATUS_OK},
         '{OP_LOAD, 32'h0000_0000, 1'b0, 12'h000, CHK_MODEL, 16'h0000, STATUS_OK},
         '{OP_LOAD, 32'hFFFF_FFFF, 1'b0, 12'hAAA, CHK_MODEL, 16'h0000, STATUS_OK},
         '{OP_LOAD, 32'h0000_0001, 1'b0, 12'h555, CHK_MODEL, 16'h0000, STATUS_OK},
         // the peak reads 0 dB; zero and one LSB sit below the floor
         '{OP_READ, 32'h0000_0000, 1'b0, 12'h002, CHK_FIXED, 16'h0000, STATUS_OK},
         '{OP_READ, 32'h0000_0000, 1'b0, 12'h001, CHK_FIXED, floor_level, STATUS_OK},
         '{OP_READ, 32'h0000_0000, 1'b0, 12'h003, CHK_FIXED, floor_level, STATUS_OK},
         '{OP_READ, 32'h0000_0000, 1'b0, 12'h000, CHK_MODEL, 16'h0000, STATUS_OK},
         '{OP_READ, 32'h0000_0000, 1'b0, 12'h004, CHK_FIXED, 16'h0000, STATUS_UNLOADED},
         // restart: old entries are out of reach
         '{OP_LOAD, 32'h8000_0000, 1'b1, 12'h000, CHK_MODEL, 16'h0000, STATUS_OK},
         '{OP_READ, 32'h0000_0000, 1'b0, 12'h001, CHK_FIXED, 16'h0000, STATUS_UNLOADED},
         '{OP_READ, 32'h0000_0000, 1'b0, 12'h000, CHK_FIXED, 16'h0000, STATUS_OK},
         // a set of only zero power keeps the peak at eps
         '{OP_LOAD, 32'h0000_0000, 1'b1, 12'h000, CHK_MODEL, 16'h0000, STATUS_OK},
         '{OP_READ, 32'h0000_0000, 1'b0, 12'h000, CHK_FIXED, 16'h0000, STATUS_OK},
         '{OP_LOAD, 32'h0000_0003, 1'b0, 12'h000, CHK_MODEL, 16'h0000, STATUS_OK},
         '{OP_READ, 32'h0000_0000, 1'b0, 12'h000, CHK_MODEL, 16'h0000, STATUS_OK},
         '{OP_READ, 32'h0000_0000, 1'b0, 12'h001, CHK_FIXED, 16'h0000, STATUS_OK},
         // a read ignores its first flag
         '{OP_LOAD, 32'h7FFF_FFFF, 1'b1, 12'hFFF, CHK_MODEL, 16'h0000, STATUS_OK},
         '{OP_READ, 32'hFFFF_FFFF, 1'b1, 12'h000, CHK_FIXED, 16'h0000, STATUS_OK}
      };

      // hold reset, then release it
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the reset floor depth
      foreach (dir_tbl[i]) begin
         beat_type b;
         b.op    = dir_tbl[i].op;
         b.pwr   = dir_tbl[i].pwr;
         b.first = dir_tbl[i].first;
         b.idx   = dir_tbl[i].idx;
         issue(b, dir_tbl[i].chk, dir_tbl[i].db, dir_tbl[i].st);
      end

      // zero floor: every read gives 0 dB
      write_top_db('0);
      run_sets(140);

      // deepest floor, no idling on the request side
      write_top_db('1);
      gaps_on = 1'b0;
      run_sets(160);
      gaps_on = 1'b1;

      write_top_db(TOP_DB_W'(1));
      run_sets(140);

      write_top_db(TOP_DB_W'($urandom));
      run_sets(160);

      write_top_db(TOP_DB_RESET);
      run_sets(140);

      write_top_db(TOP_DB_W'($urandom_range(256, 8192)));
      run_sets(190);

      write_top_db(TOP_DB_W'($urandom));
      run_sets(160);

      // drain: let every response land, then watch for strays
      req_tvalid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      fault_count += pending_levels.size();
      if (fault_count == 0) begin
         $display("power_to_db_ref_max_core verification clean");
      end else begin
         $display("power_to_db_ref_max_core verification failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: random back-pressure, runs of ready with short and long
   // stalls between them
   // ------------------------------------------------------------------------
   initial begin : rsp_pace
      int on_len, off_len, r;
      @(negedge reset);
      forever begin
         on_len = $urandom_range(1, 40);
         rsp_tready <= 1'b1;
         repeat (on_len) @(posedge clock);
         r = $urandom_range(0, 99);
         if (r < 30) off_len = 0;
         else if (r < 90) off_len = $urandom_range(1, 3);
         else off_len = $urandom_range(12, 40);
         if (off_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Checker: compare each response beat with the oldest pending level
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_levels.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected response: db %0d status %0b",
                        $signed(rsp_tdata), rsp_tuser);
         end else begin
            level_type e;
            e = pending_levels.pop_front();
            if (rsp_tdata !== e.db || rsp_tuser !== e.st) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("level mismatch: expected db %0d status %0b, got db %0d status %0b",
                           $signed(e.db), e.st, $signed(rsp_tdata), rsp_tuser);
            end
         end
      end
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("power_to_db_ref_max_core verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ptdb_pkg.sv
design/ptdb_store.sv
design/ptdb_log.sv
design/power_to_db_ref_max_core.sv
tb/power_to_db_ref_max_core_test.sv
